// ===== design/tkis_pkg.sv =====
// Package for the top-k index select unit.
// Holds field widths, configuration register codes and the control struct of one chain cell.
// No dependencies.
`default_nettype none

package tkis_pkg;

  localparam int KEY_W      = 32;
  localparam int RANK_POS_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int COUNT_W    = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT_WANTED  = 2'd0,
    CFG_ORDER_LARGEST = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
    logic clear;
    logic order_largest;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/top_k_index_select_unit.sv =====
// Top level of the top-k index select unit: streaming partial sort over a chain of cells.
// Depends on tkis_pkg and tkis_cell.
//
// Input channel (in_valid / in_stall) carries error_value and is_last_item, numbered
// from 0 in arrival order. Each item enters the sorted chain as it is taken: every cell
// compares its key with the new one, and the item lands where the first cell gives way.
// Up to MAX_ITEMS items per set are ranked; later ones are dropped and flag overflowed.
// After the item marked is_last_item, the unit raises in_stall and drains min(K, held)
// results on the output channel (out_valid / out_stall), best first, one per cycle
// while out_stall is low. The first result is valid the cycle after the last item.
// Result values come straight from the head cell, which only moves when a result is
// taken, so a stalled result holds. The chain is emptied as the final result is taken,
// and the next item can be taken in the cycle after.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 writes count_wanted,
// index 1 writes order_largest. Reset clears the chain, counters and flags and sets
// K to 1 with smallest-first ordering.
`default_nettype none

module top_k_index_select_unit #(
  parameter int MAX_ITEMS = 64,
  parameter int MAX_K     = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [tkis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [tkis_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire [tkis_pkg::KEY_W-1:0]        error_value,
  input  wire                              is_last_item,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [tkis_pkg::RANK_POS_W-1:0]  rank_position,
  output logic [tkis_pkg::KEY_W-1:0]       rank_value,
  output logic                             is_last_result,
  output logic                             overflowed
);

  localparam int PosW  = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
  localparam int CntW  = $clog2(MAX_ITEMS + 1);
  localparam int HeldW = $clog2(MAX_K + 1);
  localparam int CmpW  = ((HeldW > tkis_pkg::COUNT_W) ? HeldW : tkis_pkg::COUNT_W) + 1;

  logic [tkis_pkg::COUNT_W-1:0] count_wanted;
  logic                         order_largest;
  logic                         busy;
  logic [HeldW-1:0]             remaining;
  logic [HeldW-1:0]             held_count;
  logic [CntW-1:0]              item_counter;
  logic                         overflow_flag;
  logic                         out_overflow;

  logic                         accept_in;
  logic                         accept_out;
  logic                         insert;
  logic                         inserted;
  logic                         overflow_after;
  logic [HeldW-1:0]             held_after;
  logic [HeldW-1:0]             k_sat;
  logic [HeldW-1:0]             n_report;
  tkis_pkg::cell_ctrl_t         ctrl;

  logic                         cell_valid [MAX_K];
  logic [tkis_pkg::KEY_W-1:0]   cell_key   [MAX_K];
  logic [PosW-1:0]              cell_pos   [MAX_K];
  logic                         prefix     [MAX_K+1];

  assign cfg_ready  = 1'b1;
  assign in_stall   = busy;
  assign out_valid  = busy;
  assign accept_in  = in_valid && !busy;
  assign accept_out = busy && !out_stall;

  always_comb begin
    insert         = accept_in && (item_counter < CntW'(MAX_ITEMS));
    inserted       = insert && prefix[MAX_K];
    overflow_after = overflow_flag || (accept_in && !insert);
    if (inserted && (held_count != HeldW'(MAX_K))) begin
      held_after = held_count + HeldW'(1);
    end else begin
      held_after = held_count;
    end
    if (count_wanted == '0) begin
      k_sat = HeldW'(1);
    end else if (CmpW'(count_wanted) > CmpW'(MAX_K)) begin
      k_sat = HeldW'(MAX_K);
    end else begin
      k_sat = HeldW'(count_wanted);
    end
    n_report = (held_after < k_sat) ? held_after : k_sat;
    ctrl.insert        = insert;
    ctrl.shift_out     = accept_out;
    ctrl.order_largest = order_largest;
    ctrl.clear         = (accept_in && is_last_item && (n_report == '0)) ||
                         (accept_out && (remaining == HeldW'(1)));
  end

  assign prefix[0] = 1'b0;

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic                       prev_valid;
    logic [tkis_pkg::KEY_W-1:0] prev_key;
    logic [PosW-1:0]            prev_pos;
    logic                       next_valid;
    logic [tkis_pkg::KEY_W-1:0] next_key;
    logic [PosW-1:0]            next_pos;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b0;
      assign prev_key   = '0;
      assign prev_pos   = '0;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
      assign prev_key   = cell_key[i-1];
      assign prev_pos   = cell_pos[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_key   = '0;
      assign next_pos   = '0;
    end else begin : g_link
      assign next_valid = cell_valid[i+1];
      assign next_key   = cell_key[i+1];
      assign next_pos   = cell_pos[i+1];
    end

    tkis_cell #(
      .POS_W(PosW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_key    (error_value),
      .new_pos    (item_counter[PosW-1:0]),
      .prev_valid (prev_valid),
      .prev_key   (prev_key),
      .prev_pos   (prev_pos),
      .next_valid (next_valid),
      .next_key   (next_key),
      .next_pos   (next_pos),
      .prefix_in  (prefix[i]),
      .prefix_out (prefix[i+1]),
      .valid      (cell_valid[i]),
      .key        (cell_key[i]),
      .pos        (cell_pos[i])
    );
  end

  assign rank_position  = tkis_pkg::RANK_POS_W'(cell_pos[0]);
  assign rank_value     = cell_key[0];
  assign is_last_result = (remaining == HeldW'(1));
  assign overflowed     = out_overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_wanted  <= tkis_pkg::COUNT_W'(1);
      order_largest <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tkis_pkg::CFG_COUNT_WANTED:  count_wanted  <= cfg_data[tkis_pkg::COUNT_W-1:0];
        tkis_pkg::CFG_ORDER_LARGEST: order_largest <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      remaining     <= '0;
      held_count    <= '0;
      item_counter  <= '0;
      overflow_flag <= 1'b0;
      out_overflow  <= 1'b0;
    end else if (accept_in) begin
      if (is_last_item) begin
        item_counter  <= '0;
        overflow_flag <= 1'b0;
        out_overflow  <= overflow_after;
        remaining     <= n_report;
        if (n_report == '0) begin
          held_count <= '0;
        end else begin
          held_count <= held_after;
          busy       <= 1'b1;
        end
      end else begin
        held_count    <= held_after;
        overflow_flag <= overflow_after;
        if (insert) begin
          item_counter <= item_counter + CntW'(1);
        end
      end
    end else if (accept_out) begin
      remaining <= remaining - HeldW'(1);
      if (remaining == HeldW'(1)) begin
        busy       <= 1'b0;
        held_count <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/tkis_cell.sv =====
// One cell of the sorted chain: holds one key and its arrival position.
// Inserts by comparing with the new key, shifts toward the tail on insert, toward the head on drain.
// Depends on tkis_pkg.
`default_nettype none

module tkis_cell #(
  parameter int POS_W = 6
) (
  input  wire                          clk,
  input  wire                          rst,
  input  tkis_pkg::cell_ctrl_t         ctrl,
  input  wire [tkis_pkg::KEY_W-1:0]    new_key,
  input  wire [POS_W-1:0]              new_pos,
  input  wire                          prev_valid,
  input  wire [tkis_pkg::KEY_W-1:0]    prev_key,
  input  wire [POS_W-1:0]              prev_pos,
  input  wire                          next_valid,
  input  wire [tkis_pkg::KEY_W-1:0]    next_key,
  input  wire [POS_W-1:0]              next_pos,
  input  wire                          prefix_in,
  output logic                         prefix_out,
  output logic                         valid,
  output logic [tkis_pkg::KEY_W-1:0]   key,
  output logic [POS_W-1:0]             pos
);

  logic stays_ahead;
  logic take_new;

  always_comb begin
    if (ctrl.order_largest) begin
      stays_ahead = (key >= new_key);
    end else begin
      stays_ahead = (key <= new_key);
    end
    take_new   = !valid || !stays_ahead;
    prefix_out = prefix_in || take_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift_out) begin
      valid <= next_valid;
    end else if (ctrl.insert) begin
      if (prefix_in) begin
        valid <= prev_valid;
      end else if (take_new) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_out) begin
      key <= next_key;
      pos <= next_pos;
    end else if (ctrl.insert) begin
      if (prefix_in) begin
        key <= prev_key;
        pos <= prev_pos;
      end else if (take_new) begin
        key <= new_key;
        pos <= new_pos;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/tkis_checker.sv =====
// Port-level checker for the top-k index select unit, bound to the top level.
// Depends on tkis_pkg and top_k_index_select_unit.
`default_nettype none

module tkis_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              in_valid,
  input wire                              in_stall,
  input wire                              is_last_item,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire [tkis_pkg::RANK_POS_W-1:0]   rank_position,
  input wire [tkis_pkg::KEY_W-1:0]        rank_value,
  input wire                              is_last_result
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rank_position) && $stable(rank_value))
    else $error("stalled result changed");

  // last item of a set always yields at least one result
  a_last_reports: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && is_last_item |=> out_valid)
    else $error("no result after last item");

  // no new item while results drain
  a_drain_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken during drain");

  // drain ends exactly after the marked result
  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && is_last_result |=> !out_valid)
    else $error("results continue after final");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !is_last_result |=> out_valid)
    else $error("drain stopped before final result");

endmodule

bind top_k_index_select_unit tkis_checker u_tkis_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .is_last_item   (is_last_item),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .rank_position  (rank_position),
  .rank_value     (rank_value),
  .is_last_result (is_last_result)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for top_k_index_select_unit: directed table, then random sets of error items.
// Expected ranks come from a local sorted-list model, or from the table for typed rows, and are checked in order.
// Depends on tkis_pkg and the design files.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ITEMS     = 64;
  localparam int MAX_K         = 16;
  localparam int RANDOM_ITEMS  = 380;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [tkis_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [tkis_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [tkis_pkg::KEY_W-1:0]     KEY_INF     = '1;

  typedef struct packed {
    logic [tkis_pkg::RANK_POS_W-1:0] pos;
    logic [tkis_pkg::KEY_W-1:0]      value;
    logic                            last;
    logic                            ovf;
  } rank_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_ITEM_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [tkis_pkg::CFG_IDX_W-1:0]  idx;
    logic [tkis_pkg::CFG_DATA_W-1:0] data;
    logic [tkis_pkg::KEY_W-1:0]      value;
    logic                            last;
    rank_t                           typed;
  } row_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [tkis_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tkis_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [tkis_pkg::KEY_W-1:0]      error_value;
  logic                            is_last_item;
  logic                            out_valid;
  logic                            out_stall;
  logic [tkis_pkg::RANK_POS_W-1:0] rank_position;
  logic [tkis_pkg::KEY_W-1:0]      rank_value;
  logic                            is_last_result;
  logic                            overflowed;

  top_k_index_select_unit #(
    .MAX_ITEMS(MAX_ITEMS),
    .MAX_K(MAX_K)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .error_value(error_value),
    .is_last_item(is_last_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rank_position(rank_position),
    .rank_value(rank_value),
    .is_last_result(is_last_result),
    .overflowed(overflowed)
  );

  // sorted list model
  logic [tkis_pkg::KEY_W-1:0]      kept_keys [MAX_K];
  logic [tkis_pkg::RANK_POS_W-1:0] kept_pos  [MAX_K];
  int                              kept_n;
  int                              set_n;
  logic                            set_dropped;
  logic [tkis_pkg::COUNT_W-1:0]    want_k;
  logic                            want_largest;

  rank_t pending_ranks [$];
  int    fail_count;
  int    cycle_count;
  int    in_gap_pct;
  int    out_stall_pct;
  int    stall_left;
  row_t  dir_rows [$];

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bit keeps_place(logic [tkis_pkg::KEY_W-1:0] held,
                                     logic [tkis_pkg::KEY_W-1:0] fresh);
    if (want_largest)
      return held >= fresh;
    return held <= fresh;
  endfunction

  function automatic void place_key(logic [tkis_pkg::KEY_W-1:0] key, int pos);
    int p;
    int tail;
    p = 0;
    while (p < kept_n && p < MAX_K && keeps_place(kept_keys[p], key))
      p++;
    if (p >= MAX_K)
      return;
    tail = (kept_n < MAX_K) ? kept_n : MAX_K - 1;
    for (int i = tail; i > p; i--) begin
      kept_keys[i] = kept_keys[i-1];
      kept_pos[i]  = kept_pos[i-1];
    end
    kept_keys[p] = key;
    kept_pos[p]  = pos[tkis_pkg::RANK_POS_W-1:0];
    if (kept_n < MAX_K)
      kept_n++;
  endfunction

  function automatic void rank_error_value(logic [tkis_pkg::KEY_W-1:0] key, logic last_flag,
                                           bit typed_on, rank_t typed);
    int k;
    int n;
    rank_t r;
    if (set_n < MAX_ITEMS) begin
      place_key(key, set_n);
      set_n++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last_flag)
      return;
    k = int'(want_k);
    if (k == 0)
      k = 1;
    if (k > MAX_K)
      k = MAX_K;
    n = (kept_n < k) ? kept_n : k;
    if (typed_on) begin
      pending_ranks = {pending_ranks, typed};
    end else begin
      for (int i = 0; i < n; i++) begin
        r.pos   = kept_pos[i];
        r.value = kept_keys[i];
        r.last  = (i + 1 == n);
        r.ovf   = set_dropped;
        pending_ranks = {pending_ranks, r};
      end
    end
    kept_n      = 0;
    set_n       = 0;
    set_dropped = 1'b0;
  endfunction

  function automatic void add_row(row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  function automatic row_t cfg_row(logic [tkis_pkg::CFG_IDX_W-1:0] idx,
                                   logic [tkis_pkg::CFG_DATA_W-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic row_t item_row(logic [tkis_pkg::KEY_W-1:0] value, logic last_flag);
    row_t r;
    r = '0;
    r.kind  = ROW_ITEM;
    r.value = value;
    r.last  = last_flag;
    return r;
  endfunction

  function automatic row_t typed_row(logic [tkis_pkg::KEY_W-1:0] value,
                                     logic [tkis_pkg::RANK_POS_W-1:0] pos,
                                     logic [tkis_pkg::KEY_W-1:0] ranked);
    row_t r;
    r = '0;
    r.kind        = ROW_ITEM_TYPED;
    r.value       = value;
    r.last        = 1'b1;
    r.typed.pos   = pos;
    r.typed.value = ranked;
    r.typed.last  = 1'b1;
    r.typed.ovf   = 1'b0;
    return r;
  endfunction

  function automatic logic [tkis_pkg::KEY_W-1:0] pick_error(int style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 7);
      2: return KEY_INF - $urandom_range(0, 3);
      3: return ($urandom_range(0, 1) == 1) ? KEY_INF : '0;
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic [tkis_pkg::KEY_W-1:0] key, input logic last_flag,
                           input bit typed_on, input rank_t typed);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid     = 1'b1;
    error_value  = key;
    is_last_item = last_flag;
    forever begin
      @(posedge clk);
      if (!in_stall)
        break;
    end
    rank_error_value(key, last_flag, typed_on, typed);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_ranks.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [tkis_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tkis_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    forever begin
      @(posedge clk);
      if (cfg_ready)
        break;
    end
    case (idx)
      tkis_pkg::CFG_COUNT_WANTED:  want_k = data;
      tkis_pkg::CFG_ORDER_LARGEST: want_largest = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  = 1'b1;
      stall_left = stall_left - 1;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      out_stall  = 1'b1;
      stall_left = $urandom_range(1, 17) - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    rank_t want_rank;
    if (!rst && out_valid && !out_stall) begin
      if (pending_ranks.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: pos %0d value %h last %0d ovf %0d",
                   rank_position, rank_value, is_last_result, overflowed);
      end else begin
        want_rank = pending_ranks.pop_front();
        if (rank_position !== want_rank.pos || rank_value !== want_rank.value ||
            is_last_result !== want_rank.last || overflowed !== want_rank.ovf) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch: expected pos %0d value %h last %0d ovf %0d,",
                     want_rank.pos, want_rank.value, want_rank.last, want_rank.ovf,
                     " got pos %0d value %h last %0d ovf %0d",
                     rank_position, rank_value, is_last_result, overflowed);
        end
      end
    end
  end

  initial begin
    int items_sent;
    int set_size;
    int k_pick;
    bit calm;
    bit first_big;
    rank_t no_rank;

    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    error_value   = '0;
    is_last_item  = 1'b0;
    out_stall     = 1'b0;
    stall_left    = 0;
    in_gap_pct    = 0;
    out_stall_pct = 0;
    fail_count    = 0;
    cycle_count   = 0;
    kept_n        = 0;
    set_n         = 0;
    set_dropped   = 1'b0;
    want_k        = 5'd1;
    want_largest  = 1'b0;
    no_rank       = '0;
    items_sent    = 0;
    first_big     = 1'b1;

    // after reset: one best, smallest first
    add_row(typed_row(32'd5, 6'd0, 32'd5));
    add_row(typed_row(KEY_INF, 6'd0, KEY_INF));
    add_row(item_row(32'd7, 1'b0));
    add_row(item_row(32'd0, 1'b0));
    add_row(typed_row(KEY_INF, 6'd1, 32'd0));
    // k above range, ties, fewer items than k, largest first
    add_row(cfg_row(tkis_pkg::CFG_COUNT_WANTED, 5'd31));
    add_row(item_row(32'd9, 1'b0));
    add_row(item_row(32'd9, 1'b0));
    add_row(item_row(32'd9, 1'b1));
    add_row(cfg_row(tkis_pkg::CFG_ORDER_LARGEST, 5'h1F));
    add_row(item_row(32'd0, 1'b0));
    add_row(item_row(KEY_INF, 1'b0));
    add_row(item_row(32'd3, 1'b0));
    add_row(item_row(KEY_INF, 1'b1));
    // k of zero acts as one
    add_row(cfg_row(tkis_pkg::CFG_COUNT_WANTED, 5'd0));
    add_row(item_row(32'd0, 1'b0));
    add_row(typed_row(32'd1, 6'd1, 32'd1));
    // order flipped in the middle of a set
    add_row(cfg_row(tkis_pkg::CFG_COUNT_WANTED, 5'd16));
    add_row(cfg_row(tkis_pkg::CFG_ORDER_LARGEST, 5'h1E));
    add_row(item_row(32'd4, 1'b0));
    add_row(item_row(32'd8, 1'b0));
    add_row(cfg_row(tkis_pkg::CFG_ORDER_LARGEST, 5'h01));
    add_row(item_row(32'd6, 1'b0));
    add_row(item_row(32'd2, 1'b0));
    add_row(item_row(32'd5, 1'b1));
    // unused register codes change nothing
    add_row(cfg_row(CFG_SPARE_A, 5'h1F));
    add_row(cfg_row(CFG_SPARE_B, 5'h00));
    add_row(cfg_row(tkis_pkg::CFG_COUNT_WANTED, 5'd2));
    add_row(item_row(32'h8000_0000, 1'b0));
    add_row(item_row(32'h7FFF_FFFF, 1'b1));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    in_gap_pct    = 20;
    out_stall_pct = 20;
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG:        write_reg(dir_rows[i].idx, dir_rows[i].data);
        ROW_ITEM:       send_item(dir_rows[i].value, dir_rows[i].last, 1'b0, no_rank);
        ROW_ITEM_TYPED: send_item(dir_rows[i].value, dir_rows[i].last, 1'b1, dir_rows[i].typed);
        default: ;
      endcase
    end

    while (items_sent < RANDOM_ITEMS) begin
      calm          = items_sent > (RANDOM_ITEMS * 85) / 100;
      in_gap_pct    = (calm || $urandom_range(0, 2) == 0) ? 0 : 20;
      out_stall_pct = (calm || $urandom_range(0, 2) == 0) ? 0 : 20;
      k_pick = $urandom_range(0, 5);
      case (k_pick)
        0: write_reg(tkis_pkg::CFG_COUNT_WANTED, 5'd1);
        1: write_reg(tkis_pkg::CFG_COUNT_WANTED, 5'd16);
        2: write_reg(tkis_pkg::CFG_COUNT_WANTED, 5'd0);
        3: write_reg(tkis_pkg::CFG_COUNT_WANTED, 5'd31);
        default: write_reg(tkis_pkg::CFG_COUNT_WANTED,
                           tkis_pkg::CFG_DATA_W'($urandom_range(1, 16)));
      endcase
      write_reg(tkis_pkg::CFG_ORDER_LARGEST, tkis_pkg::CFG_DATA_W'($urandom_range(0, 31)));
      repeat ($urandom_range(1, 3)) begin
        if (first_big)
          set_size = 70;
        else if ($urandom_range(0, 9) == 0)
          set_size = $urandom_range(60, 72);
        else
          set_size = $urandom_range(1, 20);
        first_big = 1'b0;
        for (int i = 0; i < set_size; i++)
          send_item(pick_error($urandom_range(0, 4)), i == set_size - 1, 1'b0, no_rank);
        items_sent += set_size;
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/tkis_pkg.sv
design/tkis_cell.sv
design/top_k_index_select_unit.sv
design/tkis_checker.sv
bench/tb_top.sv
